// File: src/assert_macros.svh
// assertion macros shared by the allocator modules
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset disables the check
`define PFA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset disables the check
`define PFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pfa_pkg.sv
// shared types and constants of the page frame allocator
// no dependencies; used by every module and interface of the block
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int SIZE_W      = 16;   // block_size, owner_id, free size
    localparam int PAGE_W      = 11;   // page_size register
    localparam int CHG_W       = 14;   // frames_changed result field
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_CNT_W   = $clog2(SIZE_W);

    localparam int DEF_NUM_FRAMES = 8192;
    localparam int DEF_OWNER_BITS = 16;

    localparam logic [PAGE_W-1:0] RESET_PAGE_SIZE  = PAGE_W'(1);
    localparam logic [SIZE_W-1:0] RESET_TOTAL_SIZE = SIZE_W'(8192);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAGE_SIZE  = 1'b0,
        REG_TOTAL_SIZE = 1'b1
    } t_reg_idx;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic clr_run;
        logic load;
        logic scan_start;
        logic scan_run;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic fits;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// File: src/pfa_if.sv
// valid/ready channel interfaces: request, response and configuration write
// depends on pfa_pkg for field widths
`timescale 1ns / 1ps

interface pfa_req_if;
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [pfa_pkg::SIZE_W-1:0] owner_id;
    logic [pfa_pkg::SIZE_W-1:0] block_size;

    modport source (output valid, operation, owner_id, block_size, input ready);
    modport sink   (input valid, operation, owner_id, block_size, output ready);
endinterface

interface pfa_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       granted;
    logic [pfa_pkg::CHG_W-1:0]  frames_changed;
    logic [pfa_pkg::SIZE_W-1:0] free_size;

    modport source (output valid, granted, frames_changed, free_size, input ready);
    modport sink   (input valid, granted, frames_changed, free_size, output ready);
endinterface

interface pfa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pfa_pkg::CFG_IDX_W-1:0]  index;
    logic [pfa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/page_frame_allocator.sv
// First-fit page frame allocator. A table of NUM_FRAMES entries records the owner of each
// page frame (zero means free) next to a 16-bit free size. An allocate request that fits in
// the free size writes its owner into the first block_size / page_size free frames in
// ascending order and lowers the free size by block_size; a refused one returns granted 0
// and changes nothing. A free request clears up to that many frames of the owner, scanning
// up from frame zero, and raises the free size, saturating at its maximum. Each request
// returns one response. A request passes through the transfer, the bit-serial divider,
// then the table scan, which reads one entry a cycle through the frame table read port
// and stops when the frame count is used up or the last entry is passed, then the commit,
// which is held back while the previous response still waits in the output register; a
// refused allocation skips the scan. A new request is taken while the previous response
// still waits in the output register. After reset the table is swept to zero, one entry
// a cycle, so no request is taken until the sweep is done; configuration writes are taken
// at any time, with ready held high, and should be made only while the block is idle.
// Writing total_size (register 1) reloads the free size; page_size (register 0) sets the
// divisor.
`timescale 1ns / 1ps

module page_frame_allocator #(
    parameter int NUM_FRAMES = pfa_pkg::DEF_NUM_FRAMES,
    parameter int OWNER_BITS = pfa_pkg::DEF_OWNER_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfa_req_if.sink   i_req,
    pfa_rsp_if.source o_rsp,
    pfa_cfg_if.sink   i_cfg
);

    pfa_pkg::t_cmd              w_cmd;     // controller commands
    pfa_pkg::t_sts              w_sts;     // datapath status
    logic                       w_req_ready;
    logic                       w_div_done;
    logic [pfa_pkg::SIZE_W-1:0] w_quotient;
    logic [pfa_pkg::PAGE_W-1:0] w_page_size;
    logic                       w_cfg_we;

    // configuration writes are always taken
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;
    assign i_req.ready = w_req_ready;

    pfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // frame count of the request, started on the request transfer
    pfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_cmd.load),
        .i_dividend (i_req.block_size),
        .i_divisor  (w_page_size),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    pfa_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .OWNER_BITS (OWNER_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (w_cfg_we),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_operation      (i_req.operation),
        .i_owner_id       (i_req.owner_id),
        .i_block_size     (i_req.block_size),
        .i_div_done       (w_div_done),
        .i_quotient       (w_quotient),
        .o_page_size      (w_page_size),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_valid      (o_rsp.valid),
        .o_granted        (o_rsp.granted),
        .o_frames_changed (o_rsp.frames_changed),
        .o_free_size      (o_rsp.free_size)
    );

endmodule

// File: src/pfa_div.sv
// restoring divider, one quotient bit per cycle, frame count = size / page size
// depends on pfa_pkg; a zero divisor yields a zero quotient
`timescale 1ns / 1ps

module pfa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pfa_pkg::SIZE_W-1:0] i_dividend,
    input  logic [pfa_pkg::PAGE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pfa_pkg::SIZE_W-1:0] o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [pfa_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [pfa_pkg::PAGE_W-1:0]    r_rem;
    logic [pfa_pkg::SIZE_W-1:0]    r_quo;
    logic [pfa_pkg::PAGE_W-1:0]    r_dvs;

    logic [pfa_pkg::PAGE_W:0]      shifted;
    logic [pfa_pkg::PAGE_W+1:0]    diff;
    logic                          ge;
    logic [pfa_pkg::PAGE_W-1:0]    n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[pfa_pkg::SIZE_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        ge      = !diff[pfa_pkg::PAGE_W+1];
        n_rem   = ge ? diff[pfa_pkg::PAGE_W-1:0] : shifted[pfa_pkg::PAGE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == pfa_pkg::DIV_CNT_W'(pfa_pkg::SIZE_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[pfa_pkg::SIZE_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = (r_dvs == '0) ? '0 : r_quo;

endmodule

// File: src/pfa_ctrl.sv
// controller state machine: clearing pass, divide, table scan, result hand-off
// depends on pfa_pkg command and status structs and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  pfa_pkg::t_sts i_sts,
    output pfa_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_run = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    if (i_sts.fits) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `PFA_ASSERT_SAME(a_finish_needs_slot, i_clk, i_rst_n, o_cmd.finish, i_sts.out_free, "result committed while output register busy")
    `PFA_ASSERT_NEXT(a_load_to_div, i_clk, i_rst_n, o_cmd.load, r_state == S_DIV, "request transfer did not start the divide")
    `PFA_ASSERT_NEXT(a_refused_skips_scan, i_clk, i_rst_n, (r_state == S_DIV) && i_sts.div_done && !i_sts.fits, r_state == S_DONE, "refused allocation entered the scan")

endmodule

// File: src/pfa_dp.sv
// datapath: frame table memory, scan pipeline, free size, config and result registers
// depends on pfa_pkg and assert_macros.svh; driven by pfa_ctrl commands
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfa_dp #(
    parameter int NUM_FRAMES = pfa_pkg::DEF_NUM_FRAMES,
    parameter int OWNER_BITS = pfa_pkg::DEF_OWNER_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pfa_pkg::t_cmd                  i_cmd,
    output pfa_pkg::t_sts                  o_sts,
    input  logic                           i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_operation,
    input  logic [pfa_pkg::SIZE_W-1:0]     i_owner_id,
    input  logic [pfa_pkg::SIZE_W-1:0]     i_block_size,
    input  logic                           i_div_done,
    input  logic [pfa_pkg::SIZE_W-1:0]     i_quotient,
    output logic [pfa_pkg::PAGE_W-1:0]     o_page_size,
    input  logic                           i_rsp_ready,
    output logic                           o_rsp_valid,
    output logic                           o_granted,
    output logic [pfa_pkg::CHG_W-1:0]      o_frames_changed,
    output logic [pfa_pkg::SIZE_W-1:0]     o_free_size
);

    localparam int AW = $clog2(NUM_FRAMES);
    localparam logic [AW:0]   FRAME_END = (AW + 1)'(NUM_FRAMES);
    localparam logic [AW-1:0] FRAME_LAST = AW'(NUM_FRAMES - 1);

    // frame table, no reset: cleared by the sweep after reset
    logic [OWNER_BITS-1:0] r_mem [NUM_FRAMES];
    logic [OWNER_BITS-1:0] r_rd_data;

    logic [AW-1:0]                 r_clr_addr;
    logic [AW:0]                   r_rd_addr;
    logic                          r_cmp_vld;
    logic [AW-1:0]                 r_cmp_addr;
    logic [pfa_pkg::SIZE_W-1:0]    r_pages;
    logic [pfa_pkg::CHG_W-1:0]     r_changed;

    logic                          r_op;
    logic [OWNER_BITS-1:0]         r_owner;
    logic [pfa_pkg::SIZE_W-1:0]    r_size;
    logic                          r_fits;

    logic [pfa_pkg::PAGE_W-1:0]    r_page;
    logic [pfa_pkg::SIZE_W-1:0]    r_free;
    logic [pfa_pkg::SIZE_W-1:0]    n_free;

    logic                          r_out_vld;
    logic                          r_out_granted;
    logic [pfa_pkg::CHG_W-1:0]     r_out_changed;
    logic [pfa_pkg::SIZE_W-1:0]    r_out_free;

    logic                          in_range;
    logic                          issue;
    logic                          hit;
    logic                          we;
    logic [AW-1:0]                 wa;
    logic [OWNER_BITS-1:0]         wd;
    logic [pfa_pkg::SIZE_W:0]      sum;

    // scan pipeline: read issue, then compare and write-back in the cycle after
    always_comb begin
        in_range = r_rd_addr < FRAME_END;
        issue    = i_cmd.scan_run && in_range;
        hit      = r_cmp_vld && (r_pages != '0) &&
                   (r_op ? (r_rd_data == r_owner) : (r_rd_data == '0));
        if (i_cmd.clr_run) begin
            we = 1'b1;
            wa = r_clr_addr;
            wd = '0;
        end else begin
            we = hit;
            wa = r_cmp_addr;
            wd = r_op ? '0 : r_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_cmp_vld  <= 1'b0;
        end else begin
            if (i_cmd.clr_run) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_cmp_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_addr <= r_rd_addr[AW-1:0];
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_owner   <= OWNER_BITS'(i_owner_id);
            r_size    <= i_block_size;
            r_fits    <= (i_operation == pfa_pkg::OP_FREE) || (i_block_size <= r_free);
            r_changed <= '0;
        end else if (hit) begin
            r_changed <= r_changed + 1'b1;
        end
        if (i_cmd.scan_start) begin
            r_rd_addr <= '0;
            r_pages   <= i_quotient;
        end else begin
            if (issue) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end
            if (hit) begin
                r_pages <= r_pages - 1'b1;
            end
        end
    end

    // free size after the request, saturating on release
    always_comb begin
        sum = {1'b0, r_free} + {1'b0, r_size};
        if (r_op == pfa_pkg::OP_FREE) begin
            n_free = sum[pfa_pkg::SIZE_W] ? '1 : sum[pfa_pkg::SIZE_W-1:0];
        end else if (r_fits) begin
            n_free = r_free - r_size;
        end else begin
            n_free = r_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page    <= pfa_pkg::RESET_PAGE_SIZE;
            r_free    <= pfa_pkg::RESET_TOTAL_SIZE;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (pfa_pkg::t_reg_idx'(i_cfg_index))
                    pfa_pkg::REG_PAGE_SIZE:  r_page <= i_cfg_data[pfa_pkg::PAGE_W-1:0];
                    pfa_pkg::REG_TOTAL_SIZE: r_free <= i_cfg_data[pfa_pkg::SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end else if (i_cmd.finish) begin
                r_free <= n_free;
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_granted <= r_fits;
            r_out_changed <= r_changed;
            r_out_free    <= n_free;
        end
    end

    always_comb begin
        o_sts.clr_last  = r_clr_addr == FRAME_LAST;
        o_sts.div_done  = i_div_done;
        o_sts.fits      = r_fits;
        o_sts.scan_done = (r_pages == '0) || (!in_range && !r_cmp_vld);
        o_sts.out_free  = !r_out_vld || i_rsp_ready;
    end

    assign o_page_size      = r_page;
    assign o_rsp_valid      = r_out_vld;
    assign o_granted        = r_out_granted;
    assign o_frames_changed = r_out_changed;
    assign o_free_size      = r_out_free;

    `PFA_ASSERT_SAME(a_no_hit_in_clear, i_clk, i_rst_n, i_cmd.clr_run, !hit, "scan write during clearing pass")
    `PFA_ASSERT_NEXT(a_hit_counts, i_clk, i_rst_n, hit, r_changed == $past(r_changed) + pfa_pkg::CHG_W'(1), "frame write not counted")
    `PFA_ASSERT_SAME(a_refused_keeps_free, i_clk, i_rst_n, i_cmd.finish && !r_fits, n_free == r_free, "refused allocation changed free size")

endmodule

// File: tb/page_frame_allocator_checker.sv
// response checker for the page frame allocator: watches the three channels,
// keeps its own frame table and free size, and compares every response
// depends on pfa_pkg and the channel interfaces in pfa_if.sv
`timescale 1ns / 1ps

module page_frame_allocator_checker #(
    parameter int NUM_FRAMES = pfa_pkg::DEF_NUM_FRAMES,
    parameter int OWNER_BITS = pfa_pkg::DEF_OWNER_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pfa_req_if   req_mon,
    pfa_rsp_if   rsp_mon,
    pfa_cfg_if   cfg_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import pfa_pkg::*;

    typedef struct {
        logic              granted;
        logic [CHG_W-1:0]  frames_changed;
        logic [SIZE_W-1:0] free_size;
    } t_result;

    logic [OWNER_BITS-1:0] frame_owner [NUM_FRAMES];
    logic [PAGE_W-1:0]     page_units;
    logic [SIZE_W-1:0]     free_units;
    t_result               expected_results [$];

    // first-fit allocate or owner release, one expected response per request
    task automatic predict_request(input t_op op, input logic [SIZE_W-1:0] owner_raw,
                                   input logic [SIZE_W-1:0] size);
        t_result               res;
        logic [OWNER_BITS-1:0] owner;
        int                    pages;
        int                    changed;
        int                    sum;
        owner       = OWNER_BITS'(owner_raw);
        pages       = (page_units == '0) ? 0 : int'(size) / int'(page_units);
        changed     = 0;
        res.granted = 1'b1;
        if (op == OP_ALLOC) begin
            if (size <= free_units) begin
                for (int i = 0; i < NUM_FRAMES && pages > 0; i++) begin
                    if (frame_owner[i] == '0) begin
                        frame_owner[i] = owner;
                        pages--;
                        changed++;
                    end
                end
                free_units = free_units - size;
            end else begin
                res.granted = 1'b0;
            end
        end else begin
            for (int i = 0; i < NUM_FRAMES && pages > 0; i++) begin
                if (frame_owner[i] == owner) begin
                    frame_owner[i] = '0;
                    pages--;
                    changed++;
                end
            end
            sum        = int'(free_units) + int'(size);
            free_units = (sum > 65535) ? '1 : SIZE_W'(sum);
        end
        res.frames_changed = CHG_W'(changed);
        res.free_size      = free_units;
        expected_results.push_back(res);
    endtask

    task automatic check_response();
        t_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected response granted %0d frames_changed %0d free_size %0d",
                     $time, rsp_mon.granted, rsp_mon.frames_changed, rsp_mon.free_size);
            o_fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (rsp_mon.granted !== want.granted) begin
                $display("%0t: granted expected %0d actual %0d",
                         $time, want.granted, rsp_mon.granted);
                o_fail_count++;
            end
            if (rsp_mon.frames_changed !== want.frames_changed) begin
                $display("%0t: frames_changed expected %0d actual %0d",
                         $time, want.frames_changed, rsp_mon.frames_changed);
                o_fail_count++;
            end
            if (rsp_mon.free_size !== want.free_size) begin
                $display("%0t: free_size expected %0d actual %0d",
                         $time, want.free_size, rsp_mon.free_size);
                o_fail_count++;
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FRAMES; i++) frame_owner[i] = '0;
            page_units = RESET_PAGE_SIZE;
            free_units = RESET_TOTAL_SIZE;
            expected_results.delete();
        end else begin
            // retire first, a request taken on this edge cannot answer on it
            if (rsp_mon.valid && rsp_mon.ready) check_response();
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (t_reg_idx'(cfg_mon.index))
                    REG_PAGE_SIZE:  page_units = cfg_mon.data[PAGE_W-1:0];
                    REG_TOTAL_SIZE: free_units = cfg_mon.data;
                    default: ;
                endcase
            end
            if (req_mon.valid && req_mon.ready) begin
                predict_request(t_op'(req_mon.operation), req_mon.owner_id,
                                req_mon.block_size);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// File: tb/page_frame_allocator_tb.sv
// top of the page frame allocator testbench: clock, reset, request and
// configuration stimulus, response back-pressure and the final verdict
// depends on pfa_pkg, pfa_if.sv, the block and page_frame_allocator_checker
`timescale 1ns / 1ps

module page_frame_allocator_tb;
    import pfa_pkg::*;

    // worst case is roughly 105 full-table scans plus the sweep after reset
    // and the long hold-off; the limit keeps several times that as headroom
    localparam int CYCLE_LIMIT = 5_000_000;
    // response side hold-off longer than two full-table scans, so the block backs up
    localparam int LONG_HOLD   = 20_000;
    localparam int HOLD_AT     = 30;

    logic i_clk;
    logic i_rst_n;

    pfa_req_if req_bus ();
    pfa_rsp_if rsp_bus ();
    pfa_cfg_if cfg_bus ();

    int fail_count;
    int pending;
    int req_gap_max;

    // allocations still believed live, so that frees can hand them back
    logic [SIZE_W-1:0] live_owner [$];
    logic [SIZE_W-1:0] live_size  [$];

    page_frame_allocator #(
        .NUM_FRAMES(DEF_NUM_FRAMES),
        .OWNER_BITS(DEF_OWNER_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus),
        .i_cfg  (cfg_bus)
    );

    page_frame_allocator_checker #(
        .NUM_FRAMES(DEF_NUM_FRAMES),
        .OWNER_BITS(DEF_OWNER_BITS)
    ) chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .req_mon     (req_bus),
        .rsp_mon     (rsp_bus),
        .cfg_mon     (cfg_bus),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // one request transfer; valid is left high so a back-to-back item
    // never sees valid dropped and raised in the same step
    task automatic send_request(input t_op op, input logic [SIZE_W-1:0] owner,
                                input logic [SIZE_W-1:0] size);
        int gap;
        gap = $urandom_range(0, req_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.operation  <= op;
        req_bus.owner_id   <= owner;
        req_bus.block_size <= size;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // stop offering and wait until every response is back
    task automatic drain();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // register write, only called with the block idle
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // response side: random ready gaps, bursts with none, one long hold-off
    initial begin : response_sink
        int gap;
        int gap_max;
        int rsp_count;
        rsp_bus.ready = 1'b0;
        gap_max   = 8;
        rsp_count = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rsp_count % 20 == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_max = 0;
                    1:       gap_max = 3;
                    default: gap_max = 8;
                endcase
            end
            // the long stall fills the output register and the request stage
            gap = (rsp_count == HOLD_AT) ? LONG_HOLD : $urandom_range(0, gap_max);
            @(negedge i_clk);
            if (gap > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_bus.valid);
            rsp_count++;
        end
    end

    initial begin : stimulus
        int                page;
        int                kind;
        int                pick;
        int                units;
        logic [SIZE_W-1:0] owner;
        logic [SIZE_W-1:0] size;

        i_rst_n            = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.operation  = OP_ALLOC;
        req_bus.owner_id   = '0;
        req_bus.block_size = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_PAGE_SIZE;
        cfg_bus.data       = '0;
        req_gap_max        = 8;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, first at the reset settings: page 1, total 8192;
        // the block sweeps its table first, the handshake covers that
        send_request(OP_ALLOC, 16'd1, 16'd4);          // frames 0..3
        send_request(OP_ALLOC, 16'hFFFF, 16'd3);       // top owner id
        send_request(OP_ALLOC, 16'd2, 16'd0);          // zero size
        send_request(OP_ALLOC, 16'd3, 16'hFFFF);       // does not fit: refused
        send_request(OP_FREE, 16'd1, 16'd2);           // punch a hole at 0..1
        send_request(OP_ALLOC, 16'd4, 16'd3);          // first fit fills the hole
        send_request(OP_FREE, 16'd5, 16'd5);           // owner holds nothing
        send_request(OP_FREE, 16'hFFFF, 16'd10);       // fewer owned than asked
        send_request(OP_ALLOC, 16'd0, 16'd2);          // owner zero allocation
        send_request(OP_FREE, 16'd0, 16'd3);           // owner zero free
        send_request(OP_FREE, 16'd2, 16'hFFFF);        // free size saturates
        drain();

        write_reg(REG_PAGE_SIZE, 16'd0);               // zero page size
        send_request(OP_ALLOC, 16'd6, 16'd100);
        send_request(OP_FREE, 16'd6, 16'd50);
        drain();

        write_reg(REG_PAGE_SIZE, 16'd1024);
        write_reg(REG_TOTAL_SIZE, 16'hFFFF);
        send_request(OP_ALLOC, 16'd7, 16'hFFFF);       // 63 frames, free size to zero
        send_request(OP_ALLOC, 16'd8, 16'd1);          // nothing left: refused
        send_request(OP_FREE, 16'd7, 16'd1023);        // under one page
        send_request(OP_FREE, 16'd7, 16'hFFFF);        // clears the 63, saturates
        drain();

        write_reg(REG_PAGE_SIZE, 16'hF802);            // upper data bits dropped
        send_request(OP_ALLOC, 16'd9, 16'd5);
        drain();
        write_reg(REG_PAGE_SIZE, 16'd2047);            // widest page size
        send_request(OP_ALLOC, 16'd9, 16'd4094);
        drain();

        write_reg(REG_PAGE_SIZE, 16'd1);
        send_request(OP_ALLOC, 16'd10, 16'hFFFF);      // more than the free size: refused
        send_request(OP_FREE, 16'd10, 16'hFFFF);
        drain();
        write_reg(REG_TOTAL_SIZE, 16'd1);              // smallest non-zero total size
        send_request(OP_ALLOC, 16'd11, 16'd1);         // exact fit
        send_request(OP_ALLOC, 16'd12, 16'd1);         // refused
        drain();

        // random part: five settings, mostly allocate/free pairs of small
        // size with random owners, some raw noise over the full field range
        for (int phase = 0; phase < 5; phase++) begin
            drain();
            case ($urandom_range(0, 5))
                0, 1, 2: page = 1;
                3:       page = 2;
                4:       page = $urandom_range(1, 16);
                default: page = 1024;
            endcase
            write_reg(REG_PAGE_SIZE, CFG_DATA_W'(page));
            case ($urandom_range(0, 3))
                0:       write_reg(REG_TOTAL_SIZE, 16'hFFFF);
                1:       write_reg(REG_TOTAL_SIZE, CFG_DATA_W'($urandom_range(1, 65535)));
                2:       write_reg(REG_TOTAL_SIZE, 16'd8192);
                default: write_reg(REG_TOTAL_SIZE, CFG_DATA_W'($urandom_range(1, 300)));
            endcase
            case (phase % 3)
                0:       req_gap_max = 0;
                1:       req_gap_max = 8;
                default: req_gap_max = 3;
            endcase

            for (int n = 0; n < 16; n++) begin
                kind = $urandom_range(0, 9);
                if (kind <= 4) begin
                    units = $urandom_range(1, 32) * page + $urandom_range(0, page - 1);
                    owner = SIZE_W'($urandom_range(1, 65535));
                    size  = (units > 65535) ? 16'hFFFF : SIZE_W'(units);
                    send_request(OP_ALLOC, owner, size);
                    live_owner.push_back(owner);
                    live_size.push_back(size);
                end else if (kind <= 7 && live_owner.size() != 0) begin
                    pick = $urandom_range(0, live_owner.size() - 1);
                    send_request(OP_FREE, live_owner[pick], live_size[pick]);
                    live_owner.delete(pick);
                    live_size.delete(pick);
                end else begin
                    size = $urandom_range(0, 1) ? SIZE_W'($urandom)
                                                : SIZE_W'($urandom_range(0, 64));
                    send_request(t_op'($urandom_range(0, 1)), SIZE_W'($urandom), size);
                end
            end
        end

        drain();
        // wait for any stray response to show up
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
